// File: design/ght_pkg.sv
`default_nettype none

package ght_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned INDEX_W   = 13;
  localparam int unsigned VERSION_W = 32;
  localparam int unsigned CID_W     = 5;
  localparam int unsigned REQ_W     = 32;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_ASSIGN  = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_TEST    = 3'd4,
    OP_FIND    = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [INDEX_W-1:0]   entity_index;
    logic [VERSION_W-1:0] entity_version;
    logic [CID_W-1:0]     component_id;
    logic [REQ_W-1:0]     required_mask;
  } in_t;

  typedef struct packed {
    status_t              status;
    logic [INDEX_W-1:0]   result_index;
    logic [VERSION_W-1:0] result_version;
    logic                 component_present;
  } out_t;

  // How a slot entry is rewritten from the entry last read at the same address
  typedef enum logic [2:0] {
    WR_FRESH  = 3'd0,
    WR_REVIVE = 3'd1,
    WR_KILL   = 3'd2,
    WR_SET    = 3'd3,
    WR_CLEAR  = 3'd4
  } wr_kind_t;

  typedef struct packed {
    logic                 en;
    wr_kind_t             kind;
    logic [CID_W-1:0]     cid;
    logic [VERSION_W-1:0] version;
  } slot_wr_t;

endpackage

`default_nettype wire

// File: design/generational_handle_table.sv
`default_nettype none

// Channel   Ports                              Word
// input     in_valid  in_ready  in_data       ght_pkg::in_t
// result    out_valid out_ready out_data      ght_pkg::out_t
//
// Destroy, assign, remove, test and create of a new slot pass from accept
// through the execute and done states; create that reuses a freed slot first
// pops the free stack in a state of its own. Find scans one slot per cycle from
// its start index, a pace set by the single read port of the slot memory.
// Reset clears the state, the counters and the valid flags only; slot and free
// stack memories are never swept. A held result stalls the block in its done state.

module generational_handle_table #(
  parameter int unsigned MAX_SLOTS      = 4096,
  parameter int unsigned NUM_COMPONENTS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ght_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ght_pkg::out_t       out_data
);
  import ght_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int unsigned MW    = (NUM_COMPONENTS > REQ_W) ? NUM_COMPONENTS : REQ_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STACK = 5'b00010,
    S_EXEC  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     fc_r, fc_nxt;
  logic [CNT_W-1:0]     siu_r, siu_nxt;
  logic [CMP_W-1:0]     cursor_r, cursor_nxt;
  logic [CMP_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                 chk_valid_r, chk_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;
  out_t                 res_r, res_nxt;
  in_t                  item_r, item_nxt;
  logic [IDX_W-1:0]     sel_r, sel_nxt;

  logic [IDX_W-1:0]     stack_mem [MAX_SLOTS];
  logic [IDX_W-1:0]     stack_q_r;
  logic                 stack_rd_en;
  logic                 stack_wr_en;

  logic                 slot_rd_en;
  logic [IDX_W-1:0]     slot_rd_addr;
  logic [IDX_W-1:0]     slot_wr_addr;
  slot_wr_t             slot_wr;
  logic                 rd_valid;
  logic [VERSION_W-1:0] rd_version;
  logic [NUM_COMPONENTS-1:0] rd_mask;

  logic                 in_fire;
  logic [CMP_W-1:0]     in_idx_ext;
  logic [CMP_W-1:0]     idx_ext;
  logic                 in_range;
  logic                 cid_ok;
  logic                 present;
  logic                 match;
  logic                 scan_issue;
  logic                 out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign in_idx_ext = CMP_W'(in_data.entity_index);
  assign idx_ext    = CMP_W'(item_r.entity_index);
  assign in_range   = idx_ext < CMP_W'(siu_r);
  assign cid_ok     = 32'(item_r.component_id) < 32'(NUM_COMPONENTS);
  assign present    = |(rd_mask & (NUM_COMPONENTS'(1) << item_r.component_id));
  assign match      = rd_valid &&
                      ((MW'(rd_mask) & MW'(item_r.required_mask)) == MW'(item_r.required_mask));
  assign scan_issue = (state_r == S_SCAN) && (cursor_r < CMP_W'(siu_r));

  // Free stack: top entry at fc_r - 1
  assign stack_rd_en = in_fire && (in_data.operation == OP_CREATE);

  always_ff @(posedge clk) begin
    if (stack_rd_en) begin
      stack_q_r <= stack_mem[IDX_W'(fc_r - CNT_W'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (stack_wr_en) begin
      stack_mem[IDX_W'(fc_r)] <= IDX_W'(idx_ext);
    end
  end

  always_comb begin
    slot_rd_en   = 1'b0;
    slot_rd_addr = IDX_W'(in_idx_ext);
    case (state_r)
      S_IDLE: begin
        slot_rd_en   = in_fire;
        slot_rd_addr = IDX_W'(in_idx_ext);
      end
      S_STACK: begin
        slot_rd_en   = 1'b1;
        slot_rd_addr = stack_q_r;
      end
      S_SCAN: begin
        slot_rd_en   = scan_issue;
        slot_rd_addr = IDX_W'(cursor_r);
      end
      default: begin
        slot_rd_en   = 1'b0;
        slot_rd_addr = IDX_W'(in_idx_ext);
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    fc_nxt        = fc_r;
    siu_nxt       = siu_r;
    cursor_nxt    = cursor_r;
    chk_idx_nxt   = chk_idx_r;
    chk_valid_nxt = chk_valid_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    res_nxt       = res_r;
    item_nxt      = item_r;
    sel_nxt       = sel_r;
    stack_wr_en   = 1'b0;
    slot_wr_addr  = IDX_W'(idx_ext);
    slot_wr       = '{en: 1'b0, kind: WR_SET, cid: item_r.component_id,
                      version: item_r.entity_version + VERSION_W'(1)};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          if (in_data.operation == OP_FIND) begin
            cursor_nxt    = in_idx_ext;
            chk_valid_nxt = 1'b0;
            state_nxt     = S_SCAN;
          end else if (in_data.operation == OP_CREATE && fc_r != '0) begin
            state_nxt = S_STACK;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_STACK: begin
        sel_nxt   = stack_q_r;
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        res_nxt   = '{status: ST_BAD, result_index: '0, result_version: '0,
                      component_present: 1'b0};
        state_nxt = S_DONE;
        case (item_r.operation)
          OP_CREATE: begin
            if (fc_r != '0) begin
              slot_wr.en   = 1'b1;
              slot_wr.kind = WR_REVIVE;
              slot_wr_addr = sel_r;
              fc_nxt       = fc_r - CNT_W'(1);
              res_nxt.status         = ST_OK;
              res_nxt.result_index   = INDEX_W'(sel_r);
              res_nxt.result_version = rd_version;
            end else if (siu_r < CNT_W'(MAX_SLOTS)) begin
              slot_wr.en   = 1'b1;
              slot_wr.kind = WR_FRESH;
              slot_wr_addr = IDX_W'(siu_r);
              siu_nxt      = siu_r + CNT_W'(1);
              res_nxt.status       = ST_OK;
              res_nxt.result_index = INDEX_W'(siu_r);
            end else begin
              res_nxt.status       = ST_FULL;
              res_nxt.result_index = INDEX_W'(siu_r);
            end
          end
          OP_DESTROY: begin
            if (in_range && rd_valid && fc_r < CNT_W'(MAX_SLOTS)) begin
              slot_wr.en     = 1'b1;
              slot_wr.kind   = WR_KILL;
              stack_wr_en    = 1'b1;
              fc_nxt         = fc_r + CNT_W'(1);
              res_nxt.status = ST_OK;
            end
          end
          OP_ASSIGN: begin
            if (in_range && cid_ok) begin
              slot_wr.en     = 1'b1;
              slot_wr.kind   = WR_SET;
              res_nxt.status = ST_OK;
            end
          end
          OP_REMOVE: begin
            if (in_range && cid_ok && rd_valid && rd_version == item_r.entity_version) begin
              slot_wr.en     = 1'b1;
              slot_wr.kind   = WR_CLEAR;
              res_nxt.status = ST_OK;
            end
          end
          OP_TEST: begin
            if (in_range && cid_ok) begin
              res_nxt.status            = ST_OK;
              res_nxt.component_present = present;
            end
          end
          default: begin
            res_nxt.status = ST_BAD;
          end
        endcase
      end

      S_SCAN: begin
        // Issue one read per cycle; check the word read in the cycle before
        chk_valid_nxt = scan_issue;
        chk_idx_nxt   = cursor_r;
        if (scan_issue) begin
          cursor_nxt = cursor_r + CMP_W'(1);
        end
        if (chk_valid_r && match) begin
          res_nxt   = '{status: ST_OK, result_index: INDEX_W'(chk_idx_r),
                        result_version: rd_version, component_present: 1'b0};
          state_nxt = S_DONE;
        end else if (!scan_issue && !chk_valid_r) begin
          res_nxt   = '{status: ST_NONE, result_index: INDEX_W'(siu_r),
                        result_version: '0, component_present: 1'b0};
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fc_r        <= '0;
      siu_r       <= '0;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      siu_r       <= siu_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cursor_r   <= cursor_nxt;
    chk_idx_r  <= chk_idx_nxt;
    out_data_r <= out_data_nxt;
    res_r      <= res_nxt;
    item_r     <= item_nxt;
    sel_r      <= sel_nxt;
  end

  ght_slot_mem #(
    .MAX_SLOTS      (MAX_SLOTS),
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_slot_mem (
    .clk        (clk),
    .rd_en      (slot_rd_en),
    .rd_addr    (slot_rd_addr),
    .wr_addr    (slot_wr_addr),
    .wr         (slot_wr),
    .rd_valid   (rd_valid),
    .rd_version (rd_version),
    .rd_mask    (rd_mask)
  );

  a_free_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= siu_r)
    else $error("free count exceeds slots in use");

  a_used_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    siu_r <= CNT_W'(MAX_SLOTS))
    else $error("slots in use exceeds table size");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_wr.en || stack_wr_en) |-> (state_r == S_EXEC))
    else $error("memory written outside execute step");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised without a finished item");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    stack_wr_en |=> (fc_r != '0))
    else $error("free stack push lost");

endmodule

`default_nettype wire

// File: design/ght_slot_mem.sv
`default_nettype none

module ght_slot_mem #(
  parameter int unsigned MAX_SLOTS      = 4096,
  parameter int unsigned NUM_COMPONENTS = 32,
  localparam int unsigned IDX_W         = $clog2(MAX_SLOTS)
) (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [IDX_W-1:0]              rd_addr,
  input  wire logic [IDX_W-1:0]              wr_addr,
  input  wire ght_pkg::slot_wr_t             wr,
  output logic                               rd_valid,
  output logic [ght_pkg::VERSION_W-1:0]      rd_version,
  output logic [NUM_COMPONENTS-1:0]          rd_mask
);
  import ght_pkg::*;

  localparam int unsigned ENT_W = 1 + VERSION_W + NUM_COMPONENTS;

  logic [ENT_W-1:0]          mem [MAX_SLOTS];
  logic [ENT_W-1:0]          rd_q_r;
  logic [ENT_W-1:0]          wr_data;
  logic [NUM_COMPONENTS-1:0] bit_sel;

  assign rd_valid   = rd_q_r[ENT_W-1];
  assign rd_version = rd_q_r[ENT_W-2 -: VERSION_W];
  assign rd_mask    = rd_q_r[NUM_COMPONENTS-1:0];

  assign bit_sel = NUM_COMPONENTS'(1) << wr.cid;

  // Modify the entry held in the read register; the caller read this address last
  always_comb begin
    case (wr.kind)
      WR_FRESH:  wr_data = {1'b1, {VERSION_W{1'b0}}, {NUM_COMPONENTS{1'b0}}};
      WR_REVIVE: wr_data = {1'b1, rd_version, rd_mask};
      WR_KILL:   wr_data = {1'b0, wr.version, {NUM_COMPONENTS{1'b0}}};
      WR_SET:    wr_data = {rd_valid, rd_version, rd_mask | bit_sel};
      WR_CLEAR:  wr_data = {rd_valid, rd_version, rd_mask & ~bit_sel};
      default:   wr_data = rd_q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: tb/generational_handle_table_tb.sv
`timescale 1ns / 1ps

module generational_handle_table_tb;
  import ght_pkg::*;

  localparam int unsigned SLOTS       = 4096;
  localparam int unsigned RAND_WORDS  = 1200;
  localparam int unsigned SMALL_CAP   = 64;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  typedef struct {
    in_t  word;
    bit   fixed;
    out_t result;
  } plan_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // shadow copy of the table
  bit          slot_live [SLOTS];
  logic [31:0] slot_gen  [SLOTS];
  logic [31:0] slot_bits [SLOTS];
  logic [11:0] free_lifo [SLOTS];
  int unsigned free_depth = 0;
  int unsigned slot_count = 0;

  out_t        pending_results[$];
  plan_row_t   handle_plan[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned finds_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cycle_count = 0;

  generational_handle_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic in_t handle_word(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                      logic [31:0] ver, logic [CID_W-1:0] cid,
                                      logic [31:0] req);
    in_t w;
    w.operation      = op;
    w.entity_index   = idx;
    w.entity_version = ver;
    w.component_id   = cid;
    w.required_mask  = req;
    return w;
  endfunction

  function automatic out_t result_word(status_t st, logic [INDEX_W-1:0] idx,
                                       logic [31:0] ver, logic pres);
    out_t r;
    r.status            = st;
    r.result_index      = idx;
    r.result_version    = ver;
    r.component_present = pres;
    return r;
  endfunction

  task automatic add_row(input in_t w, input bit fixed, input out_t r);
    plan_row_t row;
    row.word   = w;
    row.fixed  = fixed;
    row.result = r;
    handle_plan = {handle_plan, row};
  endtask

  // Compute the result of one table operation and update the shadow table
  task automatic apply_handle_op(input in_t w, output out_t r);
    int unsigned idx;
    int unsigned s;
    bit          hit;
    logic [31:0] bit_sel;
    idx     = w.entity_index;
    bit_sel = 32'd1 << w.component_id;
    r = '0;
    r.status = ST_OK;
    case (w.operation)
      OP_CREATE: begin
        if (free_depth > 0) begin
          free_depth--;
          s = free_lifo[free_depth];
          slot_live[s]     = 1'b1;
          r.result_index   = INDEX_W'(s);
          r.result_version = slot_gen[s];
        end else if (slot_count < SLOTS) begin
          s = slot_count;
          slot_count++;
          slot_live[s]   = 1'b1;
          slot_gen[s]    = '0;
          slot_bits[s]   = '0;
          r.result_index = INDEX_W'(s);
        end else begin
          r.status       = ST_FULL;
          r.result_index = INDEX_W'(slot_count);
        end
      end
      OP_DESTROY: begin
        if (idx < slot_count && slot_live[idx] && free_depth < SLOTS) begin
          slot_live[idx] = 1'b0;
          slot_gen[idx]  = w.entity_version + 32'd1;
          slot_bits[idx] = '0;
          free_lifo[free_depth] = 12'(idx);
          free_depth++;
        end else begin
          r.status = ST_BAD;
        end
      end
      OP_ASSIGN: begin
        if (idx < slot_count) slot_bits[idx] |= bit_sel;
        else r.status = ST_BAD;
      end
      OP_REMOVE: begin
        if (idx < slot_count && slot_live[idx] && slot_gen[idx] == w.entity_version)
          slot_bits[idx] &= ~bit_sel;
        else
          r.status = ST_BAD;
      end
      OP_TEST: begin
        if (idx < slot_count) r.component_present = (slot_bits[idx] & bit_sel) != 0;
        else r.status = ST_BAD;
      end
      OP_FIND: begin
        hit = 1'b0;
        s   = idx;
        while (!hit && s < slot_count) begin
          if (slot_live[s] && (slot_bits[s] & w.required_mask) == w.required_mask) hit = 1'b1;
          else s++;
        end
        if (hit) begin
          r.result_index   = INDEX_W'(s);
          r.result_version = slot_gen[s];
        end else begin
          r.status       = ST_NONE;
          r.result_index = INDEX_W'(slot_count);
        end
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
  endtask

  // Present one word; returns at the edge that accepts it
  task automatic push_word(input in_t w, input bit fixed, input out_t fixed_res);
    out_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    apply_handle_op(w, r);
    if (fixed) r = fixed_res;
    pending_results = {pending_results, r};
    words_sent++;
    if (w.operation == OP_FIND) finds_sent++;
  endtask

  task automatic run_plan();
    plan_row_t row;
    while (handle_plan.size() != 0) begin
      row = handle_plan.pop_front();
      push_word(row.word, row.fixed, row.result);
    end
  endtask

  // Mostly well-formed handles on slot indices in use, with a tenth of raw noise
  task automatic random_word(output in_t w);
    int unsigned pick;
    int unsigned idx;
    w.operation      = OP_TEST;
    w.entity_version = $urandom();
    w.component_id   = CID_W'($urandom_range(31));
    w.required_mask  = $urandom();
    idx = (slot_count == 0) ? 0 : $urandom_range(slot_count - 1);
    if ($urandom_range(19) == 0) idx = slot_count;
    w.entity_index = INDEX_W'(idx);
    pick = $urandom_range(99);
    if (pick < 18 && (slot_count < SMALL_CAP || free_depth > 0)) begin
      w.operation = OP_CREATE;
    end else if (pick < 30) begin
      w.operation = OP_DESTROY;
    end else if (pick < 45) begin
      w.operation = OP_ASSIGN;
    end else if (pick < 60) begin
      w.operation = OP_REMOVE;
      if ($urandom_range(9) < 8 && idx < slot_count) w.entity_version = slot_gen[idx];
    end else if (pick < 75) begin
      w.operation = OP_TEST;
    end else if (pick < 90) begin
      w.operation = OP_FIND;
      case ($urandom_range(9))
        0, 1, 2, 3: w.required_mask = '0;
        4, 5, 6:    w.required_mask = 32'd1 << $urandom_range(31);
        7, 8:       w.required_mask = (idx < slot_count) ? slot_bits[idx] : '0;
        default:    ;
      endcase
      if ($urandom_range(3) == 0) w.entity_index = '0;
    end else begin
      w.operation    = OP_W'($urandom_range(7));
      w.entity_index = INDEX_W'($urandom());
    end
  endtask

  always @(posedge clk) begin : result_side
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %p", out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.result_index !== want.result_index) begin
          $error("result_index: expected %0d, got %0d", want.result_index,
                 out_data.result_index);
          fail_count++;
        end
        if (out_data.result_version !== want.result_version) begin
          $error("result_version: expected %0h, got %0h", want.result_version,
                 out_data.result_version);
          fail_count++;
        end
        if (out_data.component_present !== want.component_present) begin
          $error("component_present: expected %0d, got %0d", want.component_present,
                 out_data.component_present);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("generational_handle_table verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    in_t w;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 6;
    recv_idle_pct = 52;

    // empty table, small table, stale handles, wrap of the stored version
    add_row(handle_word(OP_FIND, 13'd0, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_NONE, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_DESTROY, 13'd0, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_BAD, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_UNDEF_LO, 13'd0, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_BAD, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_CREATE, 13'd0, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_OK, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_CREATE, 13'd0, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_OK, 13'd1, 32'd0, 1'b0));
    add_row(handle_word(OP_CREATE, 13'h1FFF, 32'hFFFFFFFF, 5'd31, 32'hFFFFFFFF), 1,
            result_word(ST_OK, 13'd2, 32'd0, 1'b0));
    add_row(handle_word(OP_ASSIGN, 13'd1, 32'd0, 5'd31, 32'h0), 1,
            result_word(ST_OK, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_ASSIGN, 13'd1, 32'd0, 5'd0, 32'h0), 0, '0);
    add_row(handle_word(OP_TEST, 13'd1, 32'd0, 5'd31, 32'h0), 1,
            result_word(ST_OK, 13'd0, 32'd0, 1'b1));
    add_row(handle_word(OP_TEST, 13'd1, 32'd0, 5'd5, 32'h0), 1,
            result_word(ST_OK, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_FIND, 13'd0, 32'd0, 5'd0, 32'h80000001), 1,
            result_word(ST_OK, 13'd1, 32'd0, 1'b0));
    add_row(handle_word(OP_FIND, 13'd2, 32'd0, 5'd0, 32'h80000001), 1,
            result_word(ST_NONE, 13'd3, 32'd0, 1'b0));
    add_row(handle_word(OP_FIND, 13'h1FFF, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_NONE, 13'd3, 32'd0, 1'b0));
    add_row(handle_word(OP_REMOVE, 13'd1, 32'd5, 5'd0, 32'h0), 1,
            result_word(ST_BAD, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_REMOVE, 13'd1, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_OK, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_DESTROY, 13'd1, 32'hFFFFFFFF, 5'd0, 32'h0), 1,
            result_word(ST_OK, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_DESTROY, 13'd1, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_BAD, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_ASSIGN, 13'd1, 32'd0, 5'd3, 32'h0), 1,
            result_word(ST_OK, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_TEST, 13'd1, 32'd0, 5'd3, 32'h0), 1,
            result_word(ST_OK, 13'd0, 32'd0, 1'b1));
    add_row(handle_word(OP_REMOVE, 13'd1, 32'd0, 5'd3, 32'h0), 1,
            result_word(ST_BAD, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_DESTROY, 13'd2, 32'h7FFFFFFF, 5'd0, 32'h0), 0, '0);
    add_row(handle_word(OP_CREATE, 13'd0, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_OK, 13'd2, 32'h80000000, 1'b0));
    add_row(handle_word(OP_CREATE, 13'd0, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_OK, 13'd1, 32'd0, 1'b0));
    add_row(handle_word(OP_FIND, 13'd0, 32'd0, 5'd0, 32'h00000008), 0, '0);
    add_row(handle_word(OP_TEST, 13'd1, 32'd0, 5'd3, 32'h0), 0, '0);
    run_plan();

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == RAND_WORDS / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 6;
      end
      if (n == 2 * RAND_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_word(w);
      push_word(w, 1'b0, '0);
    end

    // out-of-range handles up to the top of the index field, and a find that starts past the table
    add_row(handle_word(OP_DESTROY, 13'd4096, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_BAD, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_TEST, 13'h1FFF, 32'd0, 5'd31, 32'h0), 1,
            result_word(ST_BAD, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_UNDEF_HI, 13'd0, 32'd0, 5'd0, 32'h0), 1,
            result_word(ST_BAD, 13'd0, 32'd0, 1'b0));
    add_row(handle_word(OP_FIND, 13'd0, 32'd0, 5'd0, 32'hFFFFFFFF), 0, '0);
    add_row(handle_word(OP_FIND, 13'd4096, 32'd0, 5'd0, 32'h0), 0, '0);
    run_plan();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d words (%0d finds) under three idling patterns; checked %0d results.",
             words_sent, finds_sent, results_checked);
    $display("Table grew from empty to %0d slots, with stale, wrap and out-of-range cases.",
             slot_count);
    if (fail_count == 0) begin
      $display("generational_handle_table verification clean");
    end else begin
      $display("generational_handle_table verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/ght_pkg.sv
design/ght_slot_mem.sv
design/generational_handle_table.sv
tb/generational_handle_table_tb.sv
